### hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, idle while reset is held.
`define PSC_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds through reset.
`define PSC_ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PSC_ASSERT_RST(label, clk, rst_n, prop, msg)
`define PSC_ASSERT_ANY(label, clk, prop, msg)
`endif
`endif

### hw/rtl/psc_pkg.sv
// Types and fixed-point constants of the parabolic sine/cosine unit.
`default_nettype none
package psc_pkg;

    typedef logic signed [15:0] angle_t;      // Q3.12 input angle
    typedef logic signed [14:0] red_angle_t;  // Q2.12 angle within -pi..pi
    typedef logic signed [15:0] unit_t;       // Q1.14 result

    localparam int LANE_STAGES = 8;
    localparam int PIPE_STAGES = LANE_STAGES + 1;

    typedef logic [LANE_STAGES-1:0] lane_en_t;

    // Angle constants in Q3.12, sized for the 17-bit reduction arithmetic.
    localparam logic signed [16:0] PI_Q12      = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
    localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;

    // Parabola and correction coefficients.
    localparam logic signed [35:0] LIN_Q20  = 36'sd1335088;  // 4/pi, Q.20
    localparam logic signed [47:0] SQR_Q20  = 48'sd424972;   // 4/pi^2, Q.20
    localparam logic signed [42:0] CORR_Q16 = 43'sd14746;    // 0.225, Q.16

    localparam unit_t ONE_Q14 = 16'sd16384;

endpackage
`default_nettype wire

### hw/rtl/psc_reduce.sv
// Angle reduction stage: wrap into -pi..pi and form the cosine argument.
`default_nettype none
module psc_reduce
(
    input  logic                   clk,
    input  logic                   load,
    input  psc_pkg::angle_t        angle,
    output psc_pkg::red_angle_t    sin_arg,
    output psc_pkg::red_angle_t    cos_arg
);

    logic signed [16:0]  a_ext;
    logic signed [16:0]  a_wrap;
    logic signed [16:0]  c_sum;
    logic signed [16:0]  c_wrap;
    psc_pkg::red_angle_t sin_arg_reg;
    psc_pkg::red_angle_t sin_arg_next;
    psc_pkg::red_angle_t cos_arg_reg;
    psc_pkg::red_angle_t cos_arg_next;

    always_comb
    begin
        a_ext = 17'(angle);
        // One wrap covers the whole input range; +-pi itself stays.
        if (a_ext < -psc_pkg::PI_Q12)
        begin
            a_wrap = a_ext + psc_pkg::TWO_PI_Q12;
        end
        else if (a_ext > psc_pkg::PI_Q12)
        begin
            a_wrap = a_ext - psc_pkg::TWO_PI_Q12;
        end
        else
        begin
            a_wrap = a_ext;
        end

        c_sum = a_wrap + psc_pkg::HALF_PI_Q12;
        if (c_sum > psc_pkg::PI_Q12)
        begin
            c_wrap = c_sum - psc_pkg::TWO_PI_Q12;
        end
        else
        begin
            c_wrap = c_sum;
        end

        sin_arg_next = a_wrap[14:0];
        cos_arg_next = c_wrap[14:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sin_arg_reg <= sin_arg_next;
            cos_arg_reg <= cos_arg_next;
        end
    end

    assign sin_arg = sin_arg_reg;
    assign cos_arg = cos_arg_reg;

endmodule
`default_nettype wire

### hw/rtl/psc_para.sv
// Eight-stage lane: parabolic sine of a reduced angle with the correction term.
`default_nettype none
module psc_para
(
    input  logic                   clk,
    input  psc_pkg::lane_en_t      en,
    input  psc_pkg::red_angle_t    x,
    output psc_pkg::unit_t         y
);

    localparam logic [47:0] RND48 = 48'd1 << 29;
    localparam logic [45:0] RND46 = 46'd1 << 29;

    function automatic psc_pkg::unit_t sat_unit(input logic signed [17:0] v);
        logic signed [17:0] one_ext;
        one_ext = 18'(psc_pkg::ONE_Q14);
        if (v > one_ext)
        begin
            return psc_pkg::ONE_Q14;
        end
        else if (v < -one_ext)
        begin
            return -psc_pkg::ONE_Q14;
        end
        else
        begin
            return v[15:0];
        end
    endfunction

    // Stage 1: linear term and x*|x|
    logic [13:0]         ax;
    logic signed [35:0]  x36;
    logic signed [28:0]  x29;
    logic signed [28:0]  ax29;
    logic signed [35:0]  lin_p_next;
    logic signed [35:0]  lin_p_reg;
    logic signed [28:0]  xax_next;
    logic signed [28:0]  xax_reg;
    // Stage 2: square term
    logic signed [35:0]  lin_p2_reg;
    logic signed [47:0]  sqr_next;
    logic signed [47:0]  sqr_reg;
    // Stage 3: parabola in Q.44
    logic signed [47:0]  v_next;
    logic signed [47:0]  v_reg;
    // Stage 4: round to Q1.14 and saturate
    logic [47:0]         rsum1;
    psc_pkg::unit_t      y1_next;
    psc_pkg::unit_t      y1_reg;
    // Stage 5: y*|y| - y, Q.28
    logic [14:0]         ay;
    logic signed [15:0]  t16;
    logic signed [31:0]  prod32;
    logic signed [29:0]  diff_next;
    logic signed [29:0]  diff_reg;
    psc_pkg::unit_t      y2_reg;
    // Stage 6: scale by 0.225
    logic signed [42:0]  corr_next;
    logic signed [42:0]  corr_reg;
    psc_pkg::unit_t      y3_reg;
    // Stage 7: add y in Q.44
    logic signed [45:0]  acc_next;
    logic signed [45:0]  acc_reg;
    // Stage 8: final round and saturate
    logic [45:0]         rsum2;
    logic signed [15:0]  r2;
    psc_pkg::unit_t      y_next;
    psc_pkg::unit_t      y_reg;

    always_comb
    begin
        ax         = x[14] ? 14'(-x) : 14'(x);
        x36        = 36'(x);
        x29        = 29'(x);
        ax29       = signed'(29'(ax));
        lin_p_next = x36 * psc_pkg::LIN_Q20;
        xax_next   = x29 * ax29;

        sqr_next = 48'(xax_reg) * psc_pkg::SQR_Q20;

        v_next = (48'(lin_p2_reg) <<< 12) - sqr_reg;

        // Ties away from zero: drop one from the half for negative values.
        rsum1   = $unsigned(v_reg) + RND48 - {47'd0, v_reg[47]};
        y1_next = sat_unit(signed'(rsum1[47:30]));

        ay        = y1_reg[15] ? 15'(-y1_reg) : 15'(y1_reg);
        t16       = signed'(16'(ay)) - psc_pkg::ONE_Q14;
        prod32    = 32'(y1_reg) * 32'(t16);
        diff_next = prod32[29:0];

        corr_next = 43'(diff_reg) * psc_pkg::CORR_Q16;

        acc_next = 46'(corr_reg) + (46'(y3_reg) <<< 30);

        rsum2  = $unsigned(acc_reg) + RND46 - {45'd0, acc_reg[45]};
        r2     = signed'(rsum2[45:30]);
        y_next = sat_unit(18'(r2));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lin_p_reg <= lin_p_next;
            xax_reg   <= xax_next;
        end
        if (en[1])
        begin
            lin_p2_reg <= lin_p_reg;
            sqr_reg    <= sqr_next;
        end
        if (en[2])
        begin
            v_reg <= v_next;
        end
        if (en[3])
        begin
            y1_reg <= y1_next;
        end
        if (en[4])
        begin
            diff_reg <= diff_next;
            y2_reg   <= y1_reg;
        end
        if (en[5])
        begin
            corr_reg <= corr_next;
            y3_reg   <= y2_reg;
        end
        if (en[6])
        begin
            acc_reg <= acc_next;
        end
        if (en[7])
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule
`default_nettype wire

### hw/rtl/parabolic_sine_cosine_unit.sv
// Parabolic sine/cosine unit: Q3.12 angle in, Q1.14 sine and cosine out, nine-stage pipeline.
// The unit takes one angle per clock while angle_stall is low and returns its sine and
// cosine: one register stage wraps the angle into -pi..pi and forms the cosine argument, then
// two identical eight-stage lanes evaluate the corrected parabola (multiply, multiply,
// subtract, round, correction product, scale, add, round). Throughput is one item per cycle
// while result_stall is low, set by the fully pipelined lanes. Each stage holds its item only
// while the stage after it is full and held, so empty slots close up under a result stall and
// angle_stall rises only when all nine stages hold items.
`default_nettype none
`include "assert_macros.svh"
module parabolic_sine_cosine_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               angle_valid,
    output logic               angle_stall,
    input  psc_pkg::angle_t    angle,
    output logic               result_valid,
    input  logic               result_stall,
    output psc_pkg::unit_t     sine,
    output psc_pkg::unit_t     cosine
);

    localparam int N = psc_pkg::PIPE_STAGES;

    logic [N-1:0]        valid_reg;
    logic [N-1:0]        valid_next;
    logic [N-1:0]        en;
    psc_pkg::red_angle_t sin_arg;
    psc_pkg::red_angle_t cos_arg;
    psc_pkg::lane_en_t   lane_en;
    logic                in_acc;
    logic                out_acc;

    // A stage loads when it is empty or its item moves on.
    always_comb
    begin
        en[N-1] = !valid_reg[N-1] || !result_stall;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = en[0] ? angle_valid : valid_reg[0];
        for (int i = 1; i < N; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign lane_en = en[N-1:1];

    psc_reduce u_reduce
    (
        .clk     (clk),
        .load    (en[0]),
        .angle   (angle),
        .sin_arg (sin_arg),
        .cos_arg (cos_arg)
    );

    psc_para u_sin_lane
    (
        .clk (clk),
        .en  (lane_en),
        .x   (sin_arg),
        .y   (sine)
    );

    psc_para u_cos_lane
    (
        .clk (clk),
        .en  (lane_en),
        .x   (cos_arg),
        .y   (cosine)
    );

    assign angle_stall  = !en[0];
    assign result_valid = valid_reg[N-1];

    assign in_acc  = angle_valid && !angle_stall;
    assign out_acc = result_valid && !result_stall;

    `PSC_ASSERT_RST(a_stall_only_when_full, clk, rst_n, angle_stall |-> (&valid_reg), "input stalled with an empty stage")
    `PSC_ASSERT_RST(a_item_count, clk, rst_n, $countones(valid_reg) == $past($countones(valid_reg)) + 32'($past(in_acc)) - 32'($past(out_acc)), "item lost or repeated in the pipeline")
    `PSC_ASSERT_ANY(a_result_range, clk, result_valid |-> (sine <= psc_pkg::ONE_Q14 && sine >= -psc_pkg::ONE_Q14 && cosine <= psc_pkg::ONE_Q14 && cosine >= -psc_pkg::ONE_Q14), "result beyond unit range")

endmodule
`default_nettype wire
